// ===== rtl/core/dg_pkg.sv =====
`timescale 1ns / 1ps

package dg_pkg;

  // Work constants in Q.32, rounded to nearest.
  localparam logic [63:0] GAMMA_Q32 = 64'd2479122403;
  localparam logic [32:0] ZETA2_Q32 = 33'd7064938021;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam logic [63:0] WORK_ONE = 64'd1 << 32;
  localparam logic [31:0] INV12  = 32'((WORK_ONE + 64'd6) / 64'd12);
  localparam logic [31:0] INV120 = 32'((WORK_ONE + 64'd60) / 64'd120);
  localparam logic [31:0] INV252 = 32'((WORK_ONE + 64'd126) / 64'd252);
  localparam logic [31:0] INV240 = 32'((WORK_ONE + 64'd120) / 64'd240);
  localparam logic [31:0] INV132 = 32'((WORK_ONE + 64'd66) / 64'd132);

  localparam logic [47:0] OUT_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] OUT_MIN = {1'b1, {47{1'b0}}};

  localparam logic [4:0] MAX_STEPS = 5'd9;
  localparam logic [4:0] POLY_LAST = 5'd2;
  localparam logic [4:0] LN_LAST   = 5'd29;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_ACC_SUB_Q,
    OP_STEP,
    OP_SET_R,
    OP_TINY_GAMMA,
    OP_MUL_ZX,
    OP_ACC_ZX,
    OP_MUL_RR,
    OP_SET_R2,
    OP_MUL_C132,
    OP_P_240,
    OP_MUL_R2P,
    OP_P_K,
    OP_TAIL,
    OP_LN_INIT,
    OP_NORM,
    OP_LN_M,
    OP_MUL_MM,
    OP_LN_STEP,
    OP_MUL_FL,
    OP_LN_FIN,
    OP_OUT
  } dg_op_e;

  typedef struct packed {
    logic zero;
    logic tiny;
    logic shift_more;
    logic div_done;
    logic p_last;
    logic norm_done;
    logic ln_last;
  } dg_stat_t;

endpackage

// ===== rtl/core/digamma_fixed_point.sv =====
`timescale 1ns / 1ps

// Digamma of an unsigned fixed-point argument with IN_FRAC_BITS fraction bits, returned
// in signed Q26.22 and saturated; a zero argument raises input_error_o and returns the
// most negative value. One word is worked at a time. Every reciprocal comes from a
// shared radix-2 divider, and an argument below 8.5 that is not tiny needs one
// reciprocal per whole step (up to nine) plus the final one. The series and logarithm
// then run on one registered multiplier, dominated by 30 square-and-compare iterations
// and a normalizing shift. The input is taken again as soon as a result is loaded
// into the output register, even while that word waits.
module digamma_fixed_point #(
  parameter int IN_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] digamma_value_o,
  output logic        input_error_o
);
  import dg_pkg::*;

  dg_op_e   op;
  dg_stat_t stat;

  dg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  dg_datapath #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .x_value_i       (x_value_i),
    .op_i            (op),
    .stat_o          (stat),
    .digamma_value_o (digamma_value_o),
    .input_error_o   (input_error_o)
  );

endmodule

// ===== rtl/core/dg_div.sv =====
`timescale 1ns / 1ps

module dg_div #(
  parameter int IN_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] divisor_i,
  output logic [63:0] quot_o,
  output logic        done_o
);
  localparam int N  = 32 + IN_FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [33:0]   rem_q, rem_d;
  logic [33:0]   dvs_q, dvs_d;
  logic [63:0]   quo_q, quo_d;
  logic [34:0]   shifted;
  logic          ge;

  // The dividend is a single one bit at position N; it enters on the first step.
  assign shifted = {rem_q, (cnt_q == CW'(N))};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[62:0], ge};
      rem_d = ge ? 34'(shifted - {1'b0, dvs_q}) : shifted[33:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/dg_datapath.sv =====
`timescale 1ns / 1ps

module dg_datapath #(
  parameter int IN_FRAC_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      x_value_i,
  input  dg_pkg::dg_op_e   op_i,
  output dg_pkg::dg_stat_t stat_o,
  output logic [47:0]      digamma_value_o,
  output logic             input_error_o
);
  import dg_pkg::*;

  localparam logic [33:0] IN_ONE      = 34'd1 << IN_FRAC_BITS;
  localparam logic [33:0] TINY_LIMIT  = 34'((64'd1 << IN_FRAC_BITS) / 64'd1000000);
  localparam logic [33:0] SHIFT_LIMIT = 34'd17 << (IN_FRAC_BITS - 1);

  logic [33:0]        x2_q;
  logic signed [63:0] acc_q;
  logic [31:0]        r_q, r2_q, p_q;
  logic [33:0]        nrm_q;
  logic [5:0]         e_q;
  logic [30:0]        m_q;
  logic [29:0]        frac_q;
  logic [4:0]         cnt_q;
  logic [64:0]        prod_q;
  logic [47:0]        dig_q;
  logic               err_q;

  logic [63:0]        quot;
  logic               div_done;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        kconst;
  logic [31:0]        sq;
  logic signed [7:0]  whole;
  logic signed [40:0] whole_ln;
  logic signed [64:0] rnd;
  logic signed [54:0] qv;

  dg_div #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (op_i == OP_DIV_START),
    .divisor_i (x2_q),
    .quot_o    (quot),
    .done_o    (div_done)
  );

  always_comb begin
    mul_a = {1'b0, r_q};
    mul_b = r_q;
    case (op_i)
      OP_MUL_ZX: begin
        mul_a = ZETA2_Q32;
        mul_b = x2_q[31:0];
      end
      OP_MUL_C132: begin
        mul_a = {1'b0, INV132};
        mul_b = r2_q;
      end
      OP_MUL_R2P: begin
        mul_a = {1'b0, r2_q};
        mul_b = p_q;
      end
      OP_MUL_MM: begin
        mul_a = {2'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      OP_MUL_FL: begin
        mul_a = {3'b0, frac_q};
        mul_b = LN2_Q32;
      end
      default: begin
        mul_a = {1'b0, r_q};
        mul_b = r_q;
      end
    endcase
  end

  always_comb begin
    case (cnt_q)
      5'd0:    kconst = INV252;
      5'd1:    kconst = INV120;
      default: kconst = INV12;
    endcase
  end

  assign sq       = prod_q[61:30];
  assign whole    = $signed({2'b0, e_q}) - 8'(IN_FRAC_BITS);
  assign whole_ln = 41'(whole) * $signed({9'd0, LN2_Q32});
  // Round half up into Q.22; the arithmetic shift is a floor.
  assign rnd      = 65'(acc_q) + 65'sd512;
  assign qv       = 55'(rnd >>> 10);

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        x2_q  <= {2'b0, x_value_i};
        acc_q <= '0;
        cnt_q <= '0;
      end
      OP_ACC_SUB_Q: acc_q <= acc_q - $signed(quot);
      OP_STEP: begin
        acc_q <= acc_q - $signed(quot);
        x2_q  <= x2_q + IN_ONE;
        cnt_q <= cnt_q + 5'd1;
      end
      OP_SET_R: begin
        r_q   <= quot[31:0];
        acc_q <= acc_q - $signed({33'd0, quot[31:1]});
        cnt_q <= '0;
      end
      OP_TINY_GAMMA: acc_q <= acc_q - $signed(GAMMA_Q32);
      OP_ACC_ZX:     acc_q <= acc_q + $signed(64'(prod_q >> IN_FRAC_BITS));
      OP_SET_R2:     r2_q  <= prod_q[63:32];
      OP_P_240:      p_q   <= INV240 - prod_q[63:32];
      OP_P_K: begin
        p_q   <= kconst - prod_q[63:32];
        cnt_q <= cnt_q + 5'd1;
      end
      OP_TAIL:    acc_q <= acc_q - $signed({32'd0, prod_q[63:32]});
      OP_LN_INIT: begin
        nrm_q <= x2_q;
        e_q   <= 6'd33;
      end
      OP_NORM: begin
        if (!nrm_q[33]) begin
          nrm_q <= {nrm_q[32:0], 1'b0};
          e_q   <= e_q - 6'd1;
        end
      end
      OP_LN_M: begin
        m_q    <= nrm_q[33:3];
        frac_q <= '0;
        cnt_q  <= '0;
      end
      OP_LN_STEP: begin
        // A square at or above two gives the next bit of log2 as one.
        if (sq[31]) begin
          m_q    <= sq[31:1];
          frac_q <= {frac_q[28:0], 1'b1};
        end else begin
          m_q    <= sq[30:0];
          frac_q <= {frac_q[28:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
      end
      OP_LN_FIN: acc_q <= acc_q + $signed({32'd0, prod_q[61:30]}) + 64'(whole_ln);
      OP_OUT: begin
        if (x2_q == '0) begin
          dig_q <= OUT_MIN;
          err_q <= 1'b1;
        end else begin
          err_q <= 1'b0;
          if (qv[54:47] != {8{qv[54]}}) begin
            dig_q <= qv[54] ? OUT_MIN : OUT_MAX;
          end else begin
            dig_q <= qv[47:0];
          end
        end
      end
      default: ;
    endcase
    case (op_i)
      OP_MUL_ZX, OP_MUL_RR, OP_MUL_C132, OP_MUL_R2P, OP_MUL_MM, OP_MUL_FL: begin
        prod_q <= {32'd0, mul_a} * {33'd0, mul_b};
      end
      default: ;
    endcase
  end

  assign stat_o.zero       = (x2_q == '0);
  assign stat_o.tiny       = (x2_q <= TINY_LIMIT);
  assign stat_o.shift_more = (cnt_q < MAX_STEPS) && (x2_q < SHIFT_LIMIT);
  assign stat_o.div_done   = div_done;
  assign stat_o.p_last     = (cnt_q == POLY_LAST);
  assign stat_o.norm_done  = nrm_q[33];
  assign stat_o.ln_last    = (cnt_q == LN_LAST);

  assign digamma_value_o = dig_q;
  assign input_error_o   = err_q;

endmodule

// ===== rtl/core/dg_ctrl.sv =====
`timescale 1ns / 1ps

module dg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dg_pkg::dg_stat_t stat_i,
  output dg_pkg::dg_op_e   op_o
);
  import dg_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_CHECK = 24'h000002,
    S_TWAIT = 24'h000004,
    S_TGAM  = 24'h000008,
    S_TMUL  = 24'h000010,
    S_TACC  = 24'h000020,
    S_SCHK  = 24'h000040,
    S_SWAIT = 24'h000080,
    S_RWAIT = 24'h000100,
    S_RR    = 24'h000200,
    S_R2    = 24'h000400,
    S_C132  = 24'h000800,
    S_P240  = 24'h001000,
    S_PMUL  = 24'h002000,
    S_PK    = 24'h004000,
    S_TMUL2 = 24'h008000,
    S_TAIL  = 24'h010000,
    S_LNI   = 24'h020000,
    S_NORM  = 24'h040000,
    S_MM    = 24'h080000,
    S_LNS   = 24'h100000,
    S_FL    = 24'h200000,
    S_LNF   = 24'h400000,
    S_FIN   = 24'h800000
  } dg_state_e;

  dg_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.zero) begin
          state_d = S_FIN;
        end else if (stat_i.tiny) begin
          op_o    = OP_DIV_START;
          state_d = S_TWAIT;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_TWAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_ACC_SUB_Q;
          state_d = S_TGAM;
        end
      end
      S_TGAM: begin
        op_o    = OP_TINY_GAMMA;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        op_o    = OP_MUL_ZX;
        state_d = S_TACC;
      end
      S_TACC: begin
        op_o    = OP_ACC_ZX;
        state_d = S_FIN;
      end
      S_SCHK: begin
        op_o    = OP_DIV_START;
        state_d = stat_i.shift_more ? S_SWAIT : S_RWAIT;
      end
      S_SWAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_STEP;
          state_d = S_SCHK;
        end
      end
      S_RWAIT: begin
        if (stat_i.div_done) begin
          op_o    = OP_SET_R;
          state_d = S_RR;
        end
      end
      S_RR: begin
        op_o    = OP_MUL_RR;
        state_d = S_R2;
      end
      S_R2: begin
        op_o    = OP_SET_R2;
        state_d = S_C132;
      end
      S_C132: begin
        op_o    = OP_MUL_C132;
        state_d = S_P240;
      end
      S_P240: begin
        op_o    = OP_P_240;
        state_d = S_PMUL;
      end
      S_PMUL: begin
        op_o    = OP_MUL_R2P;
        state_d = S_PK;
      end
      S_PK: begin
        op_o    = OP_P_K;
        state_d = stat_i.p_last ? S_TMUL2 : S_PMUL;
      end
      S_TMUL2: begin
        op_o    = OP_MUL_R2P;
        state_d = S_TAIL;
      end
      S_TAIL: begin
        op_o    = OP_TAIL;
        state_d = S_LNI;
      end
      S_LNI: begin
        op_o    = OP_LN_INIT;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (stat_i.norm_done) begin
          op_o    = OP_LN_M;
          state_d = S_MM;
        end else begin
          op_o = OP_NORM;
        end
      end
      S_MM: begin
        op_o    = OP_MUL_MM;
        state_d = S_LNS;
      end
      S_LNS: begin
        op_o    = OP_LN_STEP;
        state_d = stat_i.ln_last ? S_FL : S_MM;
      end
      S_FL: begin
        op_o    = OP_MUL_FL;
        state_d = S_LNF;
      end
      S_LNF: begin
        op_o    = OP_LN_FIN;
        state_d = S_FIN;
      end
      S_FIN: begin
        // Load the result register once the previous word has left it.
        if (!out_valid_q || out_ready_i) begin
          op_o        = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
